### src/nrlp_pkg.sv
// shared types and constants of the number range list parser
package nrlp_pkg;

    // element count and output number width
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // result kinds
    typedef enum logic [1:0] {
        KIND_RUN   = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // syntax error codes
    typedef enum logic [1:0] {
        ERR_COMMA_OR_DASH = 2'd0,
        ERR_NUMBER        = 2'd1,
        ERR_COMMA         = 2'd2
    } err_t;

    // one result word
    typedef struct packed {
        kind_t              kind;
        logic [COUNT_W-1:0] run_first;
        logic [COUNT_W-1:0] run_last;
        logic [COUNT_W-1:0] position;
        err_t               error_code;
        logic               list_end;
    } result_t;

    // which result words the parser produces this cycle
    typedef struct packed {
        logic run_vld;
        logic end_vld;
    } push_t;

endpackage

### src/number_range_list_parser_unit.sv
// top level of the number range list parser
//
// Input channel char_valid/char_ready/char_code takes one character word a
// cycle while char_ready is high; a zero byte ends a list. Output channel
// result_valid/result_ready gives result words: a run (kind, run_first,
// run_last, position), a done word with the element count, or a syntax
// error word; list_end marks the final word of a list.
// A character accepted into the input register is decoded from it, and its
// result words are written to the result queue for the receiver.
// Throughput: one character per cycle while char_ready is high. A character
// that closes a run and also ends the list gives two words, which the
// four-entry result queue takes together.
// When the receiver stalls, results collect in the queue and the input
// register holds its character; char_ready drops once the queue cannot
// take two more words.
// Reset clears the parser state and empties the queue; the block then waits
// for the first number of a new list.
module number_range_list_parser_unit
    import nrlp_pkg::*;
#(
    parameter int NUMBER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [15:0] run_first,
    output logic [15:0] run_last,
    output logic [15:0] position,
    output logic [1:0]  error_code,
    output logic        list_end
);

    logic       char_vld_reg;
    logic [7:0] char_reg;
    logic       space;
    logic       fire;
    push_t      push;
    result_t    run_res;
    result_t    end_res;
    result_t    result_data;

    // input register handshake
    assign fire       = char_vld_reg && space;
    assign char_ready = !char_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_vld_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            char_vld_reg <= char_valid;
        end
    end

    // input word payload
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            char_reg <= char_code;
        end
    end

    // parser
    nrlp_core #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (char_reg),
        .push      (push),
        .run_res   (run_res),
        .end_res   (end_res)
    );

    // result queue
    nrlp_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .run_res      (run_res),
        .end_res      (end_res),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // output fields
    assign kind       = result_data.kind;
    assign run_first  = result_data.run_first;
    assign run_last   = result_data.run_last;
    assign position   = result_data.position;
    assign error_code = result_data.error_code;
    assign list_end   = result_data.list_end;

endmodule

### src/nrlp_core.sv
// parser state and per-character decode producing run and end words
module nrlp_core
    import nrlp_pkg::*;
#(
    parameter int NUMBER_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] char_code,
    output push_t      push,
    output result_t    run_res,
    output result_t    end_res
);

    typedef enum logic [2:0] {
        PH_WAIT          = 3'd0,
        PH_IN_FIRST      = 3'd1,
        PH_AFTER_FIRST   = 3'd2,
        PH_EXPECT_SECOND = 3'd3,
        PH_IN_SECOND     = 3'd4,
        PH_AFTER_SECOND  = 3'd5,
        PH_DRAIN         = 3'd6
    } phase_t;

    localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = '1;
    localparam int SUM_W = ((NUMBER_WIDTH > COUNT_W) ? NUMBER_WIDTH : COUNT_W) + 1;
    localparam int ACC_W = NUMBER_WIDTH + 4;

    phase_t                  phase_reg, phase_next;
    logic [NUMBER_WIDTH-1:0] accum_reg, accum_next;
    logic [NUMBER_WIDTH-1:0] rbeg_reg, rbeg_next;
    logic [COUNT_W-1:0]      count_reg, count_next;

    logic                    digit;
    logic                    blank;
    logic [3:0]              digit_val;
    logic [ACC_W-1:0]        acc_x10;
    logic [NUMBER_WIDTH-1:0] acc_sat;
    logic                    close_second;
    logic [NUMBER_WIDTH-1:0] first_sel;
    logic [NUMBER_WIDTH-1:0] span;
    logic [SUM_W-1:0]        total;
    logic [COUNT_W-1:0]      count_sum;
    logic                    run_ok;

    logic                    run_emit;
    logic                    end_emit;
    kind_t                   end_kind;
    err_t                    end_err;
    logic [COUNT_W-1:0]      end_pos;

    // character classes
    assign digit     = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign blank     = (char_code == CH_SPACE) || (char_code == CH_TAB);
    assign digit_val = digit ? 4'(char_code - CH_ZERO) : 4'd0;

    // saturating decimal accumulate: acc * 10 + digit
    assign acc_x10 = (ACC_W'(accum_reg) << 3) + (ACC_W'(accum_reg) << 1) + ACC_W'(digit_val);
    assign acc_sat = (acc_x10 > ACC_W'(NUM_MAX)) ? NUM_MAX : acc_x10[NUMBER_WIDTH-1:0];

    // run bounds and saturating count after the run
    assign close_second = (phase_reg == PH_IN_SECOND) && !digit;
    assign first_sel    = close_second ? rbeg_reg : accum_reg;
    assign run_ok       = !close_second || (accum_reg >= rbeg_reg);
    assign span         = accum_reg - first_sel;
    assign total        = SUM_W'(count_reg) + SUM_W'(span) + SUM_W'(1);
    assign count_sum    = (total > SUM_W'(COUNT_MAX)) ? COUNT_MAX : total[COUNT_W-1:0];

    // next state and result decode
    always_comb
    begin
        phase_t             ph;
        logic [COUNT_W-1:0] cnt;
        logic               clear;
        logic               drain;

        ph         = phase_reg;
        cnt        = count_reg;
        clear      = 1'b0;
        drain      = 1'b0;
        phase_next = phase_reg;
        accum_next = accum_reg;
        rbeg_next  = rbeg_reg;
        count_next = count_reg;
        run_emit   = 1'b0;
        end_emit   = 1'b0;
        end_kind   = KIND_DONE;
        end_err    = ERR_COMMA_OR_DASH;
        end_pos    = '0;

        if (phase_reg == PH_DRAIN)
        begin
            // drop everything up to the terminator
            clear = (char_code == CH_NUL);
        end
        else
        begin
            // a non-digit ends the number being read
            if ((phase_reg == PH_IN_FIRST) && !digit)
            begin
                ph = PH_AFTER_FIRST;
            end
            if (close_second)
            begin
                ph = PH_AFTER_SECOND;
                if (run_ok)
                begin
                    run_emit = 1'b1;
                    cnt      = count_sum;
                end
            end
            phase_next = ph;
            count_next = cnt;

            if (!blank)
            begin
                unique case (ph)
                    PH_IN_FIRST, PH_IN_SECOND:
                    begin
                        accum_next = acc_sat;
                    end
                    PH_AFTER_FIRST:
                    begin
                        if (char_code == CH_DASH)
                        begin
                            rbeg_next  = accum_reg;
                            phase_next = PH_EXPECT_SECOND;
                        end
                        else if ((char_code == CH_COMMA) || (char_code == CH_NUL))
                        begin
                            run_emit   = 1'b1;
                            cnt        = count_sum;
                            count_next = cnt;
                            phase_next = PH_WAIT;
                            if (char_code == CH_NUL)
                            begin
                                end_emit = 1'b1;
                                end_kind = KIND_DONE;
                                end_pos  = cnt;
                                clear    = 1'b1;
                            end
                        end
                        else
                        begin
                            end_emit = 1'b1;
                            end_kind = KIND_ERROR;
                            end_err  = ERR_COMMA_OR_DASH;
                            clear    = 1'b1;
                            drain    = 1'b1;
                        end
                    end
                    PH_EXPECT_SECOND:
                    begin
                        if (digit)
                        begin
                            accum_next = NUMBER_WIDTH'(digit_val);
                            phase_next = PH_IN_SECOND;
                        end
                        else
                        begin
                            end_emit = 1'b1;
                            end_kind = KIND_ERROR;
                            end_err  = ERR_NUMBER;
                            clear    = 1'b1;
                            drain    = (char_code != CH_NUL);
                        end
                    end
                    PH_AFTER_SECOND:
                    begin
                        if (char_code == CH_COMMA)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else if (char_code == CH_NUL)
                        begin
                            end_emit = 1'b1;
                            end_kind = KIND_DONE;
                            end_pos  = cnt;
                            clear    = 1'b1;
                        end
                        else
                        begin
                            end_emit = 1'b1;
                            end_kind = KIND_ERROR;
                            end_err  = ERR_COMMA;
                            clear    = 1'b1;
                            drain    = 1'b1;
                        end
                    end
                    default:
                    begin
                        // waiting for the first number; stray non-digits ignored
                        if (digit)
                        begin
                            accum_next = NUMBER_WIDTH'(digit_val);
                            phase_next = PH_IN_FIRST;
                        end
                        else if (char_code == CH_NUL)
                        begin
                            end_emit = 1'b1;
                            end_kind = KIND_DONE;
                            end_pos  = cnt;
                            clear    = 1'b1;
                        end
                    end
                endcase
            end
        end

        // list finished: start afresh
        if (clear)
        begin
            accum_next = '0;
            rbeg_next  = '0;
            count_next = '0;
            phase_next = drain ? PH_DRAIN : PH_WAIT;
        end
    end

    // result words
    always_comb
    begin
        run_res.kind       = KIND_RUN;
        run_res.run_first  = COUNT_W'(first_sel);
        run_res.run_last   = COUNT_W'(accum_reg);
        run_res.position   = count_reg;
        run_res.error_code = ERR_COMMA_OR_DASH;
        run_res.list_end   = 1'b0;

        end_res.kind       = end_kind;
        end_res.run_first  = '0;
        end_res.run_last   = '0;
        end_res.position   = end_pos;
        end_res.error_code = end_err;
        end_res.list_end   = 1'b1;

        push.run_vld = fire && run_emit;
        push.end_vld = fire && end_emit;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            accum_reg <= '0;
            rbeg_reg  <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            rbeg_reg  <= rbeg_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // an error on a non-terminator character starts dropping
    assert property (@(posedge clk) disable iff (!rst_n)
        push.end_vld && (end_res.kind == KIND_ERROR) && (char_code != CH_NUL)
        |=> phase_reg == PH_DRAIN)
        else $error("error word not followed by drain phase");

    // the final word of a list clears the count
    assert property (@(posedge clk) disable iff (!rst_n)
        push.end_vld |=> (count_reg == '0) && (accum_reg == '0))
        else $error("list state not cleared after final word");
`endif

endmodule

### src/nrlp_result_fifo.sv
// result queue taking up to two words a cycle and giving one while result_ready is high
module nrlp_result_fifo
    import nrlp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  result_t run_res,
    input  result_t end_res,
    output logic    space,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    result_t           mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        push_n;
    logic              pop;
    result_t           entry0;

    // word ordering: run before done or error
    assign push_n = {1'b0, push.run_vld} + {1'b0, push.end_vld};
    assign entry0 = push.run_vld ? run_res : end_res;
    assign pop    = (count_reg != '0) && result_ready;

    assign space        = count_reg <= CNT_W'(DEPTH - 2);
    assign result_valid = count_reg != '0;
    assign result_data  = mem[rd_ptr_reg];

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= entry0;
        end
        if (push_n == 2'd2)
        begin
            mem[PTR_W'(wr_ptr_reg + 1'b1)] <= end_res;
        end
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    // never overfilled
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // a double push without a pop grows the fill by two
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) && !pop |=> count_reg == $past(count_reg) + CNT_W'(2))
        else $error("double push lost a word");
`endif

endmodule

### tb/number_range_list_parser_unit_tb.sv
// testbench of number_range_list_parser_unit: directed and random list text, predicted results
module number_range_list_parser_unit_tb
    import nrlp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_SAT = 65535;

    // phases of the list parser as the predictor tracks them
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_IN_FIRST,
        PH_AFTER_FIRST,
        PH_EXPECT_SECOND,
        PH_IN_SECOND,
        PH_AFTER_SECOND,
        PH_DRAIN
    } parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    logic [7:0]  char_code = CH_NUL;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] run_first;
    logic [15:0] run_last;
    logic [15:0] position;
    logic [1:0]  error_code;
    logic        list_end;

    // predictor state
    parse_phase_t parser_phase;
    int unsigned  number_accum;
    int unsigned  range_start;
    int unsigned  element_count;

    result_t      pending_results[$];
    logic [7:0]   list_text[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           fail_count = 0;
    int           cycle_count = 0;

    number_range_list_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .run_first    (run_first),
        .run_last     (run_last),
        .position     (position),
        .error_code   (error_code),
        .list_end     (list_end)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predictor: list bookkeeping
    function automatic void clear_list();
        parser_phase  = PH_WAIT;
        number_accum  = 0;
        range_start   = 0;
        element_count = 0;
    endfunction

    function automatic void push_run(input int unsigned first, input int unsigned last);
        result_t     word;
        int unsigned total;
        if (last >= first)
        begin
            word = '{KIND_RUN, first[15:0], last[15:0], element_count[15:0],
                     ERR_COMMA_OR_DASH, 1'b0};
            pending_results.push_back(word);
            total = element_count + (last - first) + 1;
            element_count = (total > COUNT_MAX) ? COUNT_MAX : total;
        end
    endfunction

    function automatic void push_done();
        result_t word;
        word = '{KIND_DONE, 16'd0, 16'd0, element_count[15:0], ERR_COMMA_OR_DASH, 1'b1};
        pending_results.push_back(word);
        clear_list();
    endfunction

    function automatic void push_error(input err_t code, input logic [7:0] c);
        result_t word;
        word = '{KIND_ERROR, 16'd0, 16'd0, 16'd0, code, 1'b1};
        pending_results.push_back(word);
        clear_list();
        if (c != CH_NUL)
            parser_phase = PH_DRAIN;
    endfunction

    // predictor: one accepted character word
    function automatic void parse_char(input logic [7:0] c);
        logic        is_digit;
        int unsigned digit;
        int unsigned grown;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        digit    = is_digit ? int'(c - CH_ZERO) : 0;
        if (parser_phase == PH_DRAIN)
        begin
            if (c == CH_NUL)
                clear_list();
        end
        else
        begin
            // a non-digit closes the number being read
            if (parser_phase == PH_IN_FIRST && !is_digit)
                parser_phase = PH_AFTER_FIRST;
            if (parser_phase == PH_IN_SECOND && !is_digit)
            begin
                push_run(range_start, number_accum);
                parser_phase = PH_AFTER_SECOND;
            end
            if (c != CH_SPACE && c != CH_TAB)
            begin
                case (parser_phase)
                    PH_WAIT:
                    begin
                        if (is_digit)
                        begin
                            number_accum = digit;
                            parser_phase = PH_IN_FIRST;
                        end
                        else if (c == CH_NUL)
                            push_done();
                    end
                    PH_IN_FIRST, PH_IN_SECOND:
                    begin
                        grown = number_accum * 10 + digit;
                        number_accum = (grown > NUM_SAT) ? NUM_SAT : grown;
                    end
                    PH_AFTER_FIRST:
                    begin
                        if (c == CH_DASH)
                        begin
                            range_start  = number_accum;
                            parser_phase = PH_EXPECT_SECOND;
                        end
                        else if (c == CH_COMMA || c == CH_NUL)
                        begin
                            push_run(number_accum, number_accum);
                            parser_phase = PH_WAIT;
                            if (c == CH_NUL)
                                push_done();
                        end
                        else
                            push_error(ERR_COMMA_OR_DASH, c);
                    end
                    PH_EXPECT_SECOND:
                    begin
                        if (is_digit)
                        begin
                            number_accum = digit;
                            parser_phase = PH_IN_SECOND;
                        end
                        else
                            push_error(ERR_NUMBER, c);
                    end
                    default:
                    begin
                        if (c == CH_COMMA)
                            parser_phase = PH_WAIT;
                        else if (c == CH_NUL)
                            push_done();
                        else
                            push_error(ERR_COMMA, c);
                    end
                endcase
            end
        end
    endfunction

    // result checking, sampled on the falling edge ahead of the accepting edge
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual kind %0d",
                         $time, kind);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(kind));
                check_field("run_first", want.run_first, run_first);
                check_field("run_last", want.run_last, run_last);
                check_field("position", want.position, position);
                check_field("error_code", 16'(want.error_code), 16'(error_code));
                check_field("list_end", 16'(want.list_end), 16'(list_end));
            end
        end
    end

    // sender: one character word, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = char_ready;
            @(posedge clk);
        end
        parse_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // hold the input off until every expected word has come
    task automatic wait_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // random list text
    task automatic add_blanks();
        while ($urandom_range(5) == 0)
            list_text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic add_number();
        int unsigned value;
        string       digits;
        case ($urandom_range(9))
            0: value = $urandom_range(999999, 60000);
            1: value = $urandom_range(65535);
            default: value = $urandom_range(99);
        endcase
        if ($urandom_range(15) == 0)
            list_text.push_back(CH_ZERO);
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++)
            list_text.push_back(digits[i]);
    endtask

    task automatic build_random_list();
        int items;
        int spot;
        list_text.delete();
        items = ($urandom_range(15) == 0) ? 0 : $urandom_range(5, 1);
        for (int i = 0; i < items; i++)
        begin
            if (i > 0)
                list_text.push_back(CH_COMMA);
            add_blanks();
            // stray non-digit ahead of a number
            if ($urandom_range(11) == 0)
                list_text.push_back($urandom_range(1) ? CH_DASH : 8'h61);
            add_number();
            if ($urandom_range(1))
            begin
                add_blanks();
                list_text.push_back(CH_DASH);
                add_blanks();
                add_number();
            end
            add_blanks();
        end
        list_text.push_back(CH_NUL);
        // about one list in four gets random bytes put in or overwritten
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(3, 1))
            begin
                spot = $urandom_range(list_text.size() - 1);
                if ($urandom_range(1))
                    list_text[spot] = 8'($urandom_range(255));
                else
                    list_text.insert(spot, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_random_lists(input int char_total);
        int sent;
        sent = 0;
        while (sent < char_total)
        begin
            build_random_list();
            foreach (list_text[i])
                send_char(list_text[i]);
            sent += list_text.size();
        end
    endtask

    // single numbers, spacing, stray bytes, a falling range, an empty list
    task automatic test_runs_and_spacing();
        send_char(8'hFF);
        send_text("-7\t,9-3");
        send_char(CH_NUL);
        send_char(CH_NUL);
    endtask

    // number and count saturation; the range closes on the zero byte
    task automatic test_saturation();
        send_text("0-99999");
        send_char(CH_NUL);
    endtask

    // each syntax error, one of them on the zero byte, one after a run
    task automatic test_syntax_errors();
        send_text("5x");
        send_char(CH_NUL);
        send_text("4-");
        send_char(CH_NUL);
        send_text("1-2x");
        send_char(CH_NUL);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int char_total);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random_lists(char_total);
    endtask

    // receiver stalls while the sender waits for the queue to empty
    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        send_random_lists(40);
        wait_drained();
        send_random_lists(40);
    endtask

    initial
    begin
        clear_list();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_runs_and_spacing();
        test_saturation();
        test_syntax_errors();
        test_random_traffic(0, 0, 370);
        test_random_traffic(72, 0, 370);
        test_random_traffic(0, 72, 370);
        test_random_traffic(33, 33, 370);
        test_pause_until_drained();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
